[rtl/rqsr_pkg.sv]
// ----------------------------------------------------------------------------
// rqsr_pkg: shared types for the shortest-remaining ready queue
// Record layout, operation and status codes, cell modes and sequencer states.
// ----------------------------------------------------------------------------
package rqsr_pkg;

   localparam int DEPTH = 16;
   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   typedef struct packed {
      logic [7:0]  cpu;
      logic [31:0] turnaround;
      logic [31:0] finish;
      logic [31:0] remaining;
      logic [31:0] arrival;
      logic [31:0] burst;
      logic [15:0] pid;
   } rec_type;

   typedef struct packed {
      rec_type          rec;
      logic [CNT_W-1:0] occupancy;
      logic [3:0]       found;
      logic [1:0]       status;
   } rsp_type;

   typedef enum logic [2:0] {
      OP_INSERT   = 3'd0,
      OP_DELETE   = 3'd1,
      OP_READ     = 3'd2,
      OP_SHORTEST = 3'd3,
      OP_SORT     = 3'd4,
      OP_CLEAR    = 3'd5
   } op_type;

   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_EMPTY = 2'd1,
      STAT_RANGE = 2'd2,
      STAT_FULL  = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_TAKE_PREV,
      CELL_TAKE_NEXT,
      CELL_SORT_LO,
      CELL_SORT_HI
   } cell_mode_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_SORT
   } state_type;

endpackage

[rtl/rqsr_cell.sv]
// ----------------------------------------------------------------------------
// rqsr_cell: one record slot of the queue
// Holds a record, shifts from either neighbor, or does one compare-exchange
// step on pid with the neighbor it is paired with.
// ----------------------------------------------------------------------------
module rqsr_cell (
   input  logic                   clock,
   input  rqsr_pkg::cell_mode_type mode,
   input  rqsr_pkg::rec_type      prev_rec,
   input  rqsr_pkg::rec_type      next_rec,
   output rqsr_pkg::rec_type      rec
);

   rqsr_pkg::rec_type rec_ff;
   rqsr_pkg::rec_type rec_in;

   always_comb begin
      unique case (mode)
         rqsr_pkg::CELL_HOLD:      rec_in = rec_ff;
         rqsr_pkg::CELL_TAKE_PREV: rec_in = prev_rec;
         rqsr_pkg::CELL_TAKE_NEXT: rec_in = next_rec;
         rqsr_pkg::CELL_SORT_LO:   rec_in = (next_rec.pid < rec_ff.pid) ? next_rec : rec_ff;
         rqsr_pkg::CELL_SORT_HI:   rec_in = (rec_ff.pid < prev_rec.pid) ? prev_rec : rec_ff;
         default:                  rec_in = rec_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      rec_ff <= rec_in;
   end

   assign rec = rec_ff;

endmodule

[rtl/ready_queue_shortest_remaining.sv]
// ----------------------------------------------------------------------------
// ready_queue_shortest_remaining: shortest-remaining ready queue on a row of record cells
// Insert, delete, read, clear, spare codes and errors give the result beat in the cycle after
// accept; the next request can be taken in the same cycle that beat is taken. Shortest scans
// one cell a cycle and sort runs one odd-even pass a cycle, one per occupied cell; the result
// beat is registered after the last step and no request is taken meanwhile. One beat in
// flight. Reset empties the queue and drops any pending result beat.
// ----------------------------------------------------------------------------
module ready_queue_shortest_remaining (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // operation, position, proc_ident, burst_len, arrival, remaining, finish,
   // turnaround, cpu_ident, zero pad
   input  logic [191:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // status, found_position, occupancy, out_proc_ident, out_burst_len,
   // out_arrival, out_remaining, out_finish, out_turnaround, out_cpu_ident, zero pad
   output logic [199:0] rsp_tdata
);

   localparam int DEPTH = rqsr_pkg::DEPTH;
   localparam int IDX_W = rqsr_pkg::IDX_W;
   localparam int CNT_W = rqsr_pkg::CNT_W;

   rqsr_pkg::state_type state_ff, state_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic [IDX_W-1:0]    best_ff, best_in;
   logic [IDX_W-1:0]    pos_ff, pos_in;
   rqsr_pkg::rec_type   best_rec_ff, best_rec_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rqsr_pkg::rsp_type   rsp_data_ff, rsp_data_in;

   rqsr_pkg::rec_type       cell_rec  [DEPTH];
   rqsr_pkg::cell_mode_type cell_mode [DEPTH];

   rqsr_pkg::op_type  req_op;
   logic [IDX_W-1:0]  req_pos;
   rqsr_pkg::rec_type new_rec;
   rqsr_pkg::rec_type pos_rec;
   rqsr_pkg::rec_type scan_rec;
   logic              accept;
   logic              last;
   logic              take;
   logic              shift_in_all;
   logic              shift_out;
   logic              sort_step;

   assign req_op             = rqsr_pkg::op_type'(req_tdata[2:0]);
   assign req_pos            = req_tdata[6:3];
   assign new_rec.pid        = req_tdata[22:7];
   assign new_rec.burst      = req_tdata[54:23];
   assign new_rec.arrival    = req_tdata[86:55];
   assign new_rec.remaining  = req_tdata[118:87];
   assign new_rec.finish     = req_tdata[150:119];
   assign new_rec.turnaround = req_tdata[182:151];
   assign new_rec.cpu        = req_tdata[190:183];

   assign req_tready = (state_ff == rqsr_pkg::S_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;
   assign pos_rec    = cell_rec[req_pos];
   assign scan_rec   = cell_rec[idx_ff];
   assign last       = ({1'b0, idx_ff} == (count_ff - CNT_W'(1)));
   assign take       = (idx_ff == '0) || (scan_rec.remaining <= best_rec_ff.remaining);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rqsr_pkg::S_IDLE: begin
            if (accept && count_ff != '0) begin
               if (req_op == rqsr_pkg::OP_SHORTEST) state_in = rqsr_pkg::S_SCAN;
               else if (req_op == rqsr_pkg::OP_SORT) state_in = rqsr_pkg::S_SORT;
            end
         end
         rqsr_pkg::S_SCAN: if (last) state_in = rqsr_pkg::S_IDLE;
         rqsr_pkg::S_SORT: if (last) state_in = rqsr_pkg::S_IDLE;
         default:          state_in = rqsr_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      logic                 load;
      rqsr_pkg::status_type res_status;
      logic [3:0]           res_found;
      rqsr_pkg::rec_type    res_rec;

      load         = 1'b0;
      res_status   = rqsr_pkg::STAT_OK;
      res_found    = req_pos;
      res_rec      = '0;
      count_in     = count_ff;
      idx_in       = idx_ff;
      best_in      = best_ff;
      pos_in       = pos_ff;
      best_rec_in  = best_rec_ff;
      shift_in_all = 1'b0;
      shift_out    = 1'b0;
      sort_step    = 1'b0;

      unique case (state_ff)
         rqsr_pkg::S_IDLE: begin
            idx_in = '0;
            if (accept) begin
               pos_in = req_pos;
               case (req_op) inside
                  rqsr_pkg::OP_INSERT: begin
                     load = 1'b1;
                     if (count_ff == CNT_W'(DEPTH)) begin
                        res_status = rqsr_pkg::STAT_FULL;
                     end else begin
                        shift_in_all = 1'b1;
                        count_in     = count_ff + CNT_W'(1);
                     end
                  end
                  rqsr_pkg::OP_DELETE, rqsr_pkg::OP_READ: begin
                     load = 1'b1;
                     if (count_ff == '0) begin
                        res_status = rqsr_pkg::STAT_EMPTY;
                     end else if ({1'b0, req_pos} >= count_ff) begin
                        res_status = rqsr_pkg::STAT_RANGE;
                     end else begin
                        res_rec = pos_rec;
                        if (req_op == rqsr_pkg::OP_DELETE) begin
                           shift_out = 1'b1;
                           count_in  = count_ff - CNT_W'(1);
                        end
                     end
                  end
                  rqsr_pkg::OP_SHORTEST, rqsr_pkg::OP_SORT: begin
                     if (count_ff == '0) begin
                        load       = 1'b1;
                        res_status = rqsr_pkg::STAT_EMPTY;
                     end
                  end
                  rqsr_pkg::OP_CLEAR: begin
                     load     = 1'b1;
                     count_in = '0;
                  end
                  default: load = 1'b1;
               endcase
            end
         end
         rqsr_pkg::S_SCAN: begin
            idx_in = idx_ff + IDX_W'(1);
            if (take) begin
               best_in     = idx_ff;
               best_rec_in = scan_rec;
            end
            if (last) begin
               load      = 1'b1;
               res_found = 4'(best_in);
               res_rec   = best_rec_in;
            end
         end
         rqsr_pkg::S_SORT: begin
            sort_step = 1'b1;
            idx_in    = idx_ff + IDX_W'(1);
            res_found = 4'(pos_ff);
            if (last) load = 1'b1;
         end
         default: ;
      endcase

      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (load) begin
         rsp_valid_in          = 1'b1;
         rsp_data_in.status    = res_status;
         rsp_data_in.found     = res_found;
         rsp_data_in.occupancy = count_in;
         rsp_data_in.rec       = res_rec;
      end
   end

   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         cell_mode[i] = rqsr_pkg::CELL_HOLD;
         if (shift_in_all) begin
            cell_mode[i] = rqsr_pkg::CELL_TAKE_PREV;
         end else if (shift_out && IDX_W'(i) >= req_pos) begin
            cell_mode[i] = rqsr_pkg::CELL_TAKE_NEXT;
         end else if (sort_step) begin
            if ((1'(i) == idx_ff[0]) && (CNT_W'(i + 1) < count_ff)) begin
               cell_mode[i] = rqsr_pkg::CELL_SORT_LO;
            end else if ((1'(i) != idx_ff[0]) && (i >= 1) && (CNT_W'(i) < count_ff)) begin
               cell_mode[i] = rqsr_pkg::CELL_SORT_HI;
            end
         end
      end
   end

   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      rqsr_pkg::rec_type prev_rec;
      rqsr_pkg::rec_type next_rec;

      if (g == 0) begin : g_head
         assign prev_rec = new_rec;
      end else begin : g_prev
         assign prev_rec = cell_rec[g-1];
      end

      if (g == DEPTH - 1) begin : g_tail
         assign next_rec = cell_rec[g];
      end else begin : g_next
         assign next_rec = cell_rec[g+1];
      end

      rqsr_cell u_cell (
         .clock    (clock),
         .mode     (cell_mode[g]),
         .prev_rec (prev_rec),
         .next_rec (next_rec),
         .rec      (cell_rec[g])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rqsr_pkg::S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      best_ff     <= best_in;
      pos_ff      <= pos_in;
      best_rec_ff <= best_rec_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, rsp_data_ff};

endmodule
